/* sv/red_pkg.sv */
// Shared types and constants for the run-length expander with delta output.
// Used by red_front, red_cmd_fifo, red_back and the top level.
// Depends on nothing.
package red_pkg;

	localparam int LANES = 4;
	localparam int LANE_USE = (LANES < 1) ? 1 : ((LANES > 4) ? 4 : LANES);

	localparam int IMG_W = 30;
	localparam int CNT_W = 7;
	localparam int LC_W = 3;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	localparam logic [7:0] CTRL_COUNT_MASK = 8'h7F;
	localparam logic [7:0] CTRL_LITERAL_BIT = 8'h80;

	localparam logic [1:0] PH_CONTROL = 2'd0;
	localparam logic [1:0] PH_LITERAL = 2'd1;
	localparam logic [1:0] PH_RUNVAL = 2'd2;

	typedef struct packed {
		logic [7:0]       delta;
		logic [CNT_W-1:0] count;
		logic             done;
	} cmd_t;

endpackage

/* sv/red_front.sv */
// Front end: parses the byte stream, tracks the image byte budget and
// turns every data byte into one expansion command. Uses red_pkg.
module red_front import red_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IMG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	output logic             push,
	output cmd_t             push_cmd,
	input  logic             q_full
);

	logic [IMG_W-1:0] image_q;
	logic [IMG_W-1:0] produced_q;
	logic [1:0]       phase_q;
	logic [CNT_W-1:0] pending_q;
	logic [7:0]       prev_q;

	logic             accept;
	logic             active;
	logic [IMG_W-1:0] remaining;
	logic [CNT_W-1:0] want;
	logic [CNT_W-1:0] n;

	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;
	assign active = produced_q < image_q;
	assign remaining = image_q - produced_q;
	assign want = (phase_q == PH_LITERAL) ? CNT_W'(1) : pending_q;
	assign n = ({{(IMG_W-CNT_W){1'b0}}, want} > remaining) ? remaining[CNT_W-1:0] : want;

	assign push = accept && active && (phase_q == PH_LITERAL || phase_q == PH_RUNVAL);
	assign push_cmd.delta = s_tdata - prev_q;
	assign push_cmd.count = n;
	assign push_cmd.done = ({{(IMG_W-CNT_W){1'b0}}, n} == remaining);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_q <= '0;
			produced_q <= '0;
			phase_q <= PH_CONTROL;
			pending_q <= '0;
			prev_q <= '0;
		end else begin
			if (cfg_we) begin
				image_q <= cfg_wdata;
			end
			if (accept && active) begin
				unique case (phase_q)
					PH_LITERAL: begin
						prev_q <= s_tdata;
						produced_q <= produced_q + IMG_W'(1);
						pending_q <= pending_q - CNT_W'(1);
						if (pending_q == CNT_W'(1)) begin
							phase_q <= PH_CONTROL;
						end
					end
					PH_RUNVAL: begin
						prev_q <= s_tdata;
						produced_q <= produced_q + {{(IMG_W-CNT_W){1'b0}}, n};
						pending_q <= '0;
						phase_q <= PH_CONTROL;
					end
					default: begin
						pending_q <= s_tdata[CNT_W-1:0] & CTRL_COUNT_MASK[CNT_W-1:0];
						if ((s_tdata & CTRL_COUNT_MASK) == 8'h00) begin
							phase_q <= PH_CONTROL;
						end else if ((s_tdata & CTRL_LITERAL_BIT) != 8'h00) begin
							phase_q <= PH_LITERAL;
						end else begin
							phase_q <= PH_RUNVAL;
						end
					end
				endcase
			end
		end
	end

endmodule

/* sv/red_cmd_fifo.sv */
// Short command queue between the front end and the expander.
// Holds cmd_t entries; uses red_pkg.
module red_cmd_fifo import red_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic full,
	output logic empty
);

	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [CW-1:0]     cnt_q;

	assign full = (cnt_q == CW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign pop_cmd = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + CW'(push && !full) - CW'(pop && !empty);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> !(cnt_q > CW'(QDEPTH))) else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !push) |=> empty) else $error("command queue count moved while empty");
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(full && pop && !push) |=> !full) else $error("pop did not free a slot");

endmodule

/* sv/red_back.sv */
// Back end: expands each command into result items of up to LANE_USE lanes
// and holds them in the output register. Uses red_pkg.
module red_back import red_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tuser
);

	logic             busy_q;
	logic [CNT_W-1:0] rem_q;
	logic             first_q;
	logic [7:0]       delta_q;
	logic             done_q;
	logic             valid_q;
	logic [7:0]       lane0_q;
	logic [LC_W-1:0]  lc_q;
	logic             last_q;
	logic             imgdone_q;

	logic             emit;
	logic             fin;
	logic [CNT_W-1:0] c;

	assign c = (rem_q > CNT_W'(LANE_USE)) ? CNT_W'(LANE_USE) : rem_q;
	assign emit = busy_q && (!valid_q || m_tready);
	assign fin = emit && (rem_q == c);
	assign pop = !q_empty && (!busy_q || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			valid_q <= 1'b0;
			rem_q <= '0;
			first_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
				rem_q <= q_cmd.count;
				first_q <= 1'b1;
			end else begin
				if (emit) begin
					rem_q <= rem_q - c;
					first_q <= 1'b0;
				end
				if (fin) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			delta_q <= q_cmd.delta;
			done_q <= q_cmd.done;
		end
		if (emit) begin
			lane0_q <= first_q ? delta_q : 8'h00;
			lc_q <= c[LC_W-1:0];
			last_q <= (rem_q == c);
			imgdone_q <= (rem_q == c) && done_q;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {5'b0, lc_q, 24'h000000, lane0_q};
	assign m_tlast = last_q;
	assign m_tuser = imgdone_q;

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q != '0) else $error("expander busy with nothing left");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && imgdone_q) |-> last_q) else $error("image end not on last item");
	a_lane_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (lc_q != '0 && lc_q <= LC_W'(LANE_USE))) else $error("bad lane count");

endmodule

/* sv/rle_expand_delta_encoder.sv */
// Top level of the run-length expander with delta output.
// Instantiates red_front, red_cmd_fifo and red_back; uses red_pkg.
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata[7:0] rle_byte
// m_       out  m_tvalid/m_tready    m_tdata lanes+lane_count, m_tlast, m_tuser
// cfg_     in   cfg_we               cfg_wdata[29:0] image_bytes
//
// The front end takes one byte per cycle while the command queue has room.
// Each literal or run value becomes one command; unless the output stalls, the expander
// needs one cycle per result item, ceil(count / 4) items, up to 32 for a run of 127.
// Reset clears the parser, the byte budget, the queue and the output valid flag.
// A stalled output holds its item; the queue then fills and s_tready drops.
module rle_expand_delta_encoder import red_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IMG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // rle_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,   // delta_lane0..3, lane_count, zero pad
	output logic             m_tlast,   // last_of_run
	output logic             m_tuser    // image_done
);

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	red_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	red_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.pop_cmd (pop_cmd),
		.full    (q_full),
		.empty   (q_empty)
	);

	red_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_cmd   (pop_cmd),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule
